FILE: rtl/four_function_integer_alu_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-function integer ALU.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef FOUR_FUNCTION_INTEGER_ALU_UNIT_DEFINES_SVH
`define FOUR_FUNCTION_INTEGER_ALU_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk, disabled while rst_n is low.
`define FFIA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge of clk, during reset too.
`define FFIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFIA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFIA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/ffia_pkg.sv
// ----------------------------------------------------------------------------
// ffia_pkg
// Shared constants and types of the four-function integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package ffia_pkg;

  // Operand and result width.
  localparam int unsigned DataWidth = 32;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

endpackage

`default_nettype wire

FILE: rtl/ffia_req_if.sv
// ----------------------------------------------------------------------------
// ffia_req_if
// Request channel: one operation code and two signed operands per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffia_req_if;
  logic                                  valid;
  logic                                  ready;
  ffia_pkg::func_e                       func;
  logic signed [ffia_pkg::DataWidth-1:0] operand_a;
  logic signed [ffia_pkg::DataWidth-1:0] operand_b;

  modport source (output valid, output func, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input func, input operand_a, input operand_b,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/ffia_rsp_if.sv
// ----------------------------------------------------------------------------
// ffia_rsp_if
// Response channel: one signed result and a divide-by-zero flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffia_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ffia_pkg::DataWidth-1:0] result;
  logic                                  divide_by_zero;

  modport source (output valid, output result, output divide_by_zero, input ready);
  modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

`default_nettype wire

FILE: rtl/four_function_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// four_function_integer_alu_unit
// Pipelined signed add, subtract, low-product multiply and truncating divide.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   req_i    in         func, operand_a, operand_b
//   rsp_o    out        result, divide_by_zero
//
// A new transaction can enter on every clock cycle while req_i.ready is high.
// Each passes the capture stage, the restoring divider's stages, which resolve
// one quotient bit per pipeline stage, and the output (response) register.
// Reset clears only the stage valid bits; the data registers are not reset.
// When the response side stalls, stages that hold data wait while empty stages
// further up keep filling, so req_i.ready falls only once every stage is full.
//
`default_nettype none

`include "four_function_integer_alu_unit_defines.svh"

module four_function_integer_alu_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  ffia_req_if.sink   req_i,
  ffia_rsp_if.source rsp_o
);

  localparam int unsigned W = ffia_pkg::DataWidth;
  // Stage 0 captures the request, stages 1..W each resolve one quotient bit
  // (stage 1 also does add, subtract and multiply), stage W+1 is the output.
  localparam int unsigned NumStages = W + 2;

  typedef struct packed {
    ffia_pkg::func_e func;
    logic [W-1:0]    op_a;     // raw operands, used by stage 1
    logic [W-1:0]    op_b;
    logic [W-1:0]    res;      // add, subtract or multiply result, then final
    logic [W-1:0]    rem;      // partial remainder
    logic [W-1:0]    num;      // dividend bits shifting out, quotient shifting in
    logic [W-1:0]    divisor;  // magnitude of the divisor
    logic            neg;      // quotient must be negated
    logic            dz;       // divide by zero
  } stage_t;

  // One restoring division step: shift one dividend bit into the remainder
  // and subtract the divisor if it fits.
  function automatic stage_t div_step(stage_t s);
    logic [W-1:0] trial;
    logic [W:0]   diff;
    stage_t       o;
    o     = s;
    trial = {s.rem[W-2:0], s.num[W-1]};
    diff  = {1'b0, trial} - {1'b0, s.divisor};
    o.num = {s.num[W-2:0], ~diff[W]};
    o.rem = diff[W] ? trial : diff[W-1:0];
    return o;
  endfunction

  stage_t               stage_q [NumStages];
  stage_t               stage_d [NumStages];
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   rdy;

  // A stage may load when it is empty or when its content moves on.
  assign rdy[NumStages] = rsp_o.ready;
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign req_i.ready = rdy[0];

  // Stage 0: capture the request and form operand magnitudes for the divider.
  always_comb begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    a                  = req_i.operand_a;
    b                  = req_i.operand_b;
    stage_d[0]         = '0;
    stage_d[0].func    = req_i.func;
    stage_d[0].op_a    = a;
    stage_d[0].op_b    = b;
    stage_d[0].num     = a[W-1] ? (~a + 1'b1) : a;
    stage_d[0].divisor = b[W-1] ? (~b + 1'b1) : b;
    stage_d[0].neg     = a[W-1] ^ b[W-1];
    stage_d[0].dz      = (req_i.func == ffia_pkg::FUNC_DIV) && (b == '0);
  end

  // Stage 1: add, subtract and multiply, and the first quotient bit.
  // Only the low half of the product is kept, which is the same for signed
  // and unsigned operands.
  always_comb begin
    logic [W-1:0] prod;
    prod       = stage_q[0].op_a * stage_q[0].op_b;
    stage_d[1] = div_step(stage_q[0]);
    case (stage_q[0].func)
      ffia_pkg::FUNC_ADD: stage_d[1].res = stage_q[0].op_a + stage_q[0].op_b;
      ffia_pkg::FUNC_SUB: stage_d[1].res = stage_q[0].op_a - stage_q[0].op_b;
      ffia_pkg::FUNC_MUL: stage_d[1].res = prod;
      default:            stage_d[1].res = '0;
    endcase
  end

  // Stages 2..W: remaining quotient bits.
  for (genvar k = 2; k <= W; k++) begin : g_div
    assign stage_d[k] = div_step(stage_q[k-1]);
  end

  // Output stage: apply the quotient sign and the divide-by-zero rule.
  always_comb begin
    stage_d[NumStages-1] = stage_q[NumStages-2];
    if (stage_q[NumStages-2].func == ffia_pkg::FUNC_DIV) begin
      if (stage_q[NumStages-2].dz) begin
        stage_d[NumStages-1].res = '0;
      end else if (stage_q[NumStages-2].neg) begin
        stage_d[NumStages-1].res = ~stage_q[NumStages-2].num + 1'b1;
      end else begin
        stage_d[NumStages-1].res = stage_q[NumStages-2].num;
      end
    end
  end

  // Stage registers: valid bits are reset, data is not.
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic in_valid;
    if (k == 0) begin : g_first
      assign in_valid = req_i.valid;
    end else begin : g_next
      assign in_valid = valid_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign rsp_o.valid          = valid_q[NumStages-1];
  assign rsp_o.result         = stage_q[NumStages-1].res;
  assign rsp_o.divide_by_zero = stage_q[NumStages-1].dz;

  // The request side is only blocked when every stage holds a transaction.
  `FFIA_ASSERT(a_full_when_blocked, clk_i, rst_ni, !req_i.ready |-> (&valid_q),
               "request blocked while the pipeline has an empty stage")
  // A flagged divide by zero always comes with a zero result.
  `FFIA_ASSERT(a_dz_result_zero, clk_i, rst_ni,
               (rsp_o.valid && rsp_o.divide_by_zero) |-> (rsp_o.result == '0),
               "divide by zero with a nonzero result")
  // The flag is only raised for divisions.
  `FFIA_ASSERT(a_dz_only_div, clk_i, rst_ni,
               (valid_q[0] && stage_q[0].dz) |-> (stage_q[0].func == ffia_pkg::FUNC_DIV),
               "divide by zero flagged on an operation other than divide")
  // A zero divisor on a division in flight is always flagged.
  `FFIA_ASSERT(a_zero_divisor_flagged, clk_i, rst_ni,
               (valid_q[1] && (stage_q[1].func == ffia_pkg::FUNC_DIV) &&
                (stage_q[1].divisor == '0)) |-> stage_q[1].dz,
               "zero divisor not flagged")

endmodule

`default_nettype wire
